// ----- src/sm83_pkg.sv -----
// ----------------------------------------------------------------------------
// sm83_pkg
// Shared types, state codes and opcode tables for the SM83 subset core.
// ----------------------------------------------------------------------------
package sm83_pkg;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  wbyte;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HRD,
        ST_OP,
        ST_B1,
        ST_B2,
        ST_CHK,
        ST_EXR,
        ST_W2,
        ST_RESP
    } state_t;

    localparam logic [4:0] TICK_MAX = 5'd31;

    // cycle count, zero for an unimplemented opcode
    function automatic logic [4:0] op_cycles(input logic [7:0] op);
        logic [3:0] lo4;
        logic [4:0] c;
        lo4 = op[3:0];
        c   = 5'd0;
        if (op == 8'h76) begin
            c = 5'd0;
        end else if (op[7:6] == 2'b01) begin
            c = (op[2:0] == 3'd6 || op[5:3] == 3'd6) ? 5'd8 : 5'd4;
        end else if (op[7:3] == 5'b10000) begin
            c = (op == 8'h86) ? 5'd8 : 5'd4;
        end else if (op[7:6] == 2'b00) begin
            if (op == 8'h00) c = 5'd4;
            else if (op == 8'h08) c = 5'd20;
            else if (lo4 == 4'h1) c = 5'd12;
            else if (lo4 == 4'h2 || lo4 == 4'hA || lo4 == 4'h3 || lo4 == 4'h9) c = 5'd8;
            else if (lo4 == 4'h4 || lo4 == 4'hC) c = (op == 8'h34) ? 5'd12 : 5'd4;
            else if (lo4 == 4'h6 || lo4 == 4'hE) c = (op == 8'h36) ? 5'd12 : 5'd8;
            else c = 5'd0;
        end else begin
            case (op)
                8'hC6:        c = 5'd8;
                8'hE0, 8'hF0: c = 5'd12;
                8'hE2, 8'hF2: c = 5'd8;
                8'hE8:        c = 5'd16;
                8'hF8:        c = 5'd12;
                8'hF9:        c = 5'd8;
                8'hEA, 8'hFA: c = 5'd16;
                default:      c = 5'd0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [1:0] op_len(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd1;
        if (op[7:6] == 2'b00) begin
            if (op[3:0] == 4'h1 || op == 8'h08) n = 2'd3;
            else if (op[3:0] == 4'h6 || op[3:0] == 4'hE) n = 2'd2;
        end else begin
            case (op)
                8'hEA, 8'hFA:                       n = 2'd3;
                8'hC6, 8'hE0, 8'hF0, 8'hE8, 8'hF8: n = 2'd2;
                default:                            n = 2'd1;
            endcase
        end
        return n;
    endfunction

endpackage

// ----- src/sm83_ram.sv -----
// ----------------------------------------------------------------------------
// sm83_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sm83_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sm83_front.sv -----
// ----------------------------------------------------------------------------
// sm83_front
// Input side: takes words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sm83_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sm83_pkg::item_t in_item,
    output logic            q_valid,
    output sm83_pkg::item_t q_item,
    input  logic            q_pop
);

    sm83_pkg::item_t buf_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ----- src/sm83_back.sv -----
// ----------------------------------------------------------------------------
// sm83_back
// Execution side: fetch, decode, execute, memory access and result word.
// ----------------------------------------------------------------------------
module sm83_back #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sm83_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      read_byte,
    output logic            done_flag,
    output logic [15:0]     pc_value,
    output logic [15:0]     af_value,
    output logic [15:0]     bc_value,
    output logic [15:0]     de_value,
    output logic [15:0]     hl_value,
    output logic [15:0]     sp_value
);

    sm83_pkg::state_t state_reg, state_next;
    logic [15:0] pc_reg, af_reg, bc_reg, de_reg, hl_reg, sp_reg;
    logic [15:0] pc_next, af_next, bc_next, de_next, hl_next, sp_next;
    logic [7:0]  pop_reg, pop_next;
    logic [15:0] opd_reg, opd_next;
    logic        pend_reg, pend_next;
    logic [4:0]  tsl_reg, tsl_next;
    logic [7:0]  rb_reg, rb_next;
    logic        done_reg, done_next;

    logic        we;
    logic [15:0] maddr;
    logic [7:0]  wdata, rdata;

    // execute temporaries
    logic [7:0]  a, f, src, v8, r8, e;
    logic [15:0] pv, ext;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [4:0]  s5;
    logic        s8_en;
    logic [2:0]  s8_code;
    logic [7:0]  s8_val;
    logic [15:0] sp_e;
    logic [7:0]  f_e;

    sm83_ram #(.WIDTH(8), .DEPTH(2 ** MEM_ADDR_BITS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (maddr[MEM_ADDR_BITS-1:0]),
        .wdata (wdata),
        .rdata (rdata)
    );

    function automatic logic [7:0] get8(input logic [2:0] r, input logic [15:0] bc,
                                        input logic [15:0] de, input logic [15:0] hl,
                                        input logic [7:0] aa, input logic [7:0] m);
        logic [7:0] v;
        case (r)
            3'd0:    v = bc[15:8];
            3'd1:    v = bc[7:0];
            3'd2:    v = de[15:8];
            3'd3:    v = de[7:0];
            3'd4:    v = hl[15:8];
            3'd5:    v = hl[7:0];
            3'd6:    v = m;
            default: v = aa;
        endcase
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm83_pkg::ST_IDLE;
            pc_reg    <= 16'h0;
            af_reg    <= 16'h0;
            bc_reg    <= 16'h0;
            de_reg    <= 16'h0;
            hl_reg    <= 16'h0;
            sp_reg    <= 16'h0;
            pop_reg   <= 8'h0;
            opd_reg   <= 16'h0;
            pend_reg  <= 1'b0;
            tsl_reg   <= 5'd0;
            rb_reg    <= 8'h0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            af_reg    <= af_next;
            bc_reg    <= bc_next;
            de_reg    <= de_next;
            hl_reg    <= hl_next;
            sp_reg    <= sp_next;
            pop_reg   <= pop_next;
            opd_reg   <= opd_next;
            pend_reg  <= pend_next;
            tsl_reg   <= tsl_next;
            rb_reg    <= rb_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        af_next    = af_reg;
        bc_next    = bc_reg;
        de_next    = de_reg;
        hl_next    = hl_reg;
        sp_next    = sp_reg;
        pop_next   = pop_reg;
        opd_next   = opd_reg;
        pend_next  = pend_reg;
        tsl_next   = tsl_reg;
        rb_next    = rb_reg;
        done_next  = done_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        maddr      = hl_reg;
        wdata      = 8'h0;

        a   = af_reg[15:8];
        f   = af_reg[7:0];
        src = get8(pop_reg[2:0], bc_reg, de_reg, hl_reg, a, rdata);
        v8  = get8(pop_reg[5:3], bc_reg, de_reg, hl_reg, a, rdata);
        r8  = v8 + 8'd1;
        e   = opd_reg[7:0];
        ext = {{8{e[7]}}, e};
        s9  = {1'b0, a} + {1'b0, src};
        s8_en   = 1'b0;
        s8_code = pop_reg[5:3];
        s8_val  = src;
        case (pop_reg[5:4])
            2'd0:    pv = bc_reg;
            2'd1:    pv = de_reg;
            2'd2:    pv = hl_reg;
            default: pv = sp_reg;
        endcase
        s17  = {1'b0, hl_reg} + {1'b0, pv};
        s13  = {1'b0, hl_reg[11:0]} + {1'b0, pv[11:0]};
        s5   = {1'b0, sp_reg[3:0]} + {1'b0, e[3:0]};
        sp_e = sp_reg + ext;
        f_e  = {2'b00, s5[4], ({1'b0, sp_reg[7:0]} + {1'b0, e}) > 9'h0FF, 4'h0};

        case (state_reg)
            sm83_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    rb_next   = 8'h0;
                    done_next = 1'b0;
                    maddr     = q_item.addr;
                    case (q_item.func)
                        sm83_pkg::FN_WRITE:
                        begin
                            we         = 1'b1;
                            wdata      = q_item.wbyte;
                            state_next = sm83_pkg::ST_RESP;
                        end
                        sm83_pkg::FN_READ:
                        begin
                            state_next = sm83_pkg::ST_HRD;
                        end
                        sm83_pkg::FN_TICK:
                        begin
                            if (tsl_reg != sm83_pkg::TICK_MAX) tsl_next = tsl_reg + 5'd1;
                            if (!pend_reg)
                            begin
                                maddr      = pc_reg;
                                state_next = sm83_pkg::ST_OP;
                            end
                            else
                            begin
                                state_next = sm83_pkg::ST_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = sm83_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            sm83_pkg::ST_HRD:
            begin
                rb_next    = rdata;
                state_next = sm83_pkg::ST_RESP;
            end
            sm83_pkg::ST_OP:
            begin
                if (sm83_pkg::op_cycles(rdata) == 5'd0)
                begin
                    pc_next    = pc_reg + 16'd1;
                    state_next = sm83_pkg::ST_CHK;
                end
                else
                begin
                    pop_next = rdata;
                    opd_next = 16'h0;
                    if (sm83_pkg::op_len(rdata) == 2'd1)
                    begin
                        pend_next  = 1'b1;
                        pc_next    = pc_reg + 16'd1;
                        state_next = sm83_pkg::ST_CHK;
                    end
                    else
                    begin
                        maddr      = pc_reg + 16'd1;
                        state_next = sm83_pkg::ST_B1;
                    end
                end
            end
            sm83_pkg::ST_B1:
            begin
                opd_next = {8'h0, rdata};
                if (sm83_pkg::op_len(pop_reg) == 2'd3)
                begin
                    maddr      = pc_reg + 16'd2;
                    state_next = sm83_pkg::ST_B2;
                end
                else
                begin
                    pend_next  = 1'b1;
                    pc_next    = pc_reg + 16'd2;
                    state_next = sm83_pkg::ST_CHK;
                end
            end
            sm83_pkg::ST_B2:
            begin
                opd_next   = {rdata, opd_reg[7:0]};
                pend_next  = 1'b1;
                pc_next    = pc_reg + 16'd3;
                state_next = sm83_pkg::ST_CHK;
            end
            sm83_pkg::ST_CHK:
            begin
                if (pend_reg && tsl_reg >= sm83_pkg::op_cycles(pop_reg))
                begin
                    // operand fetch for the execute step
                    case (pop_reg)
                        8'h0A:   maddr = bc_reg;
                        8'h1A:   maddr = de_reg;
                        8'hF0:   maddr = {8'hFF, opd_reg[7:0]};
                        8'hF2:   maddr = {8'hFF, bc_reg[7:0]};
                        8'hFA:   maddr = opd_reg;
                        default: maddr = hl_reg;
                    endcase
                    state_next = sm83_pkg::ST_EXR;
                end
                else
                begin
                    done_next  = 1'b0;
                    state_next = sm83_pkg::ST_RESP;
                end
            end
            sm83_pkg::ST_EXR:
            begin
                pend_next  = 1'b0;
                tsl_next   = 5'd0;
                done_next  = 1'b1;
                state_next = sm83_pkg::ST_RESP;
                if (pop_reg[7:6] == 2'b01)
                begin
                    s8_en = 1'b1;
                end
                else if (pop_reg[7:3] == 5'b10000)
                begin
                    af_next = {s9[7:0], s9[7:0] == 8'h0, 1'b0,
                               ({1'b0, a[3:0]} + {1'b0, src[3:0]}) > 5'h0F, s9[8], 4'h0};
                end
                else if (pop_reg[7:6] == 2'b00 && pop_reg[2:0] == 3'd4)
                begin
                    s8_en   = 1'b1;
                    s8_val  = r8;
                    af_next = {a, r8 == 8'h0, 1'b0, v8[3:0] == 4'hF, f[4], 4'h0};
                end
                else if (pop_reg[7:6] == 2'b00 && pop_reg[2:0] == 3'd6)
                begin
                    s8_en  = 1'b1;
                    s8_val = opd_reg[7:0];
                end
                else if (pop_reg[7:6] == 2'b00)
                begin
                    case (pop_reg[3:0])
                        4'h1, 4'h3, 4'h9:
                        begin
                            if (pop_reg[3:0] == 4'h1) pv = opd_reg;
                            else if (pop_reg[3:0] == 4'h3) pv = pv + 16'd1;
                            else
                            begin
                                pv      = hl_reg;
                                hl_next = s17[15:0];
                                af_next = {a, f[7], 1'b0, s13[12], s17[16], 4'h0};
                            end
                            if (pop_reg[3:0] != 4'h9)
                            begin
                                case (pop_reg[5:4])
                                    2'd0:    bc_next = pv;
                                    2'd1:    de_next = pv;
                                    2'd2:    hl_next = pv;
                                    default: sp_next = pv;
                                endcase
                            end
                        end
                        4'h2:
                        begin
                            we    = 1'b1;
                            wdata = a;
                            if (pop_reg == 8'h02) maddr = bc_reg;
                            else if (pop_reg == 8'h12) maddr = de_reg;
                            else
                            begin
                                maddr   = hl_reg;
                                hl_next = (pop_reg == 8'h22) ? hl_reg + 16'd1
                                                             : hl_reg - 16'd1;
                            end
                        end
                        4'hA:
                        begin
                            af_next = {rdata, f};
                            if (pop_reg == 8'h2A) hl_next = hl_reg + 16'd1;
                            else if (pop_reg == 8'h3A) hl_next = hl_reg - 16'd1;
                        end
                        4'h8:
                        begin
                            we         = 1'b1;
                            maddr      = opd_reg;
                            wdata      = sp_reg[7:0];
                            state_next = sm83_pkg::ST_W2;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    case (pop_reg)
                        8'hC6:
                        begin
                            s9      = {1'b0, a} + {1'b0, e};
                            af_next = {s9[7:0], s9[7:0] == 8'h0, 1'b0,
                                       ({1'b0, a[3:0]} + {1'b0, e[3:0]}) > 5'h0F,
                                       s9[8], 4'h0};
                        end
                        8'hE0, 8'hE2, 8'hEA:
                        begin
                            we    = 1'b1;
                            wdata = a;
                            if (pop_reg == 8'hE0) maddr = {8'hFF, e};
                            else if (pop_reg == 8'hE2) maddr = {8'hFF, bc_reg[7:0]};
                            else maddr = opd_reg;
                        end
                        8'hF0, 8'hF2, 8'hFA: af_next = {rdata, f};
                        8'hE8:
                        begin
                            sp_next = sp_e;
                            af_next = {a, f_e};
                        end
                        8'hF8:
                        begin
                            hl_next = sp_e;
                            af_next = {a, f_e};
                        end
                        8'hF9:   sp_next = hl_reg;
                        default:
                        begin
                        end
                    endcase
                end
                if (s8_en)
                begin
                    case (s8_code)
                        3'd0: bc_next = {s8_val, bc_reg[7:0]};
                        3'd1: bc_next = {bc_reg[15:8], s8_val};
                        3'd2: de_next = {s8_val, de_reg[7:0]};
                        3'd3: de_next = {de_reg[15:8], s8_val};
                        3'd4: hl_next = {s8_val, hl_reg[7:0]};
                        3'd5: hl_next = {hl_reg[15:8], s8_val};
                        3'd6:
                        begin
                            we    = 1'b1;
                            maddr = hl_reg;
                            wdata = s8_val;
                        end
                        default: af_next = {s8_val, af_next[7:0]};
                    endcase
                end
            end
            sm83_pkg::ST_W2:
            begin
                we         = 1'b1;
                maddr      = opd_reg + 16'd1;
                wdata      = sp_reg[15:8];
                state_next = sm83_pkg::ST_RESP;
            end
            sm83_pkg::ST_RESP:
            begin
                if (out_ready) state_next = sm83_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sm83_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = (state_reg == sm83_pkg::ST_RESP);
    assign read_byte = rb_reg;
    assign done_flag = done_reg;
    assign pc_value  = pc_reg;
    assign af_value  = af_reg;
    assign bc_value  = bc_reg;
    assign de_value  = de_reg;
    assign hl_value  = hl_reg;
    assign sp_value  = sp_reg;

endmodule

// ----- src/sm83_subset_cpu_core.sv -----
// ----------------------------------------------------------------------------
// sm83_subset_cpu_core
// Partial SM83 core with internal byte memory and host access.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | func, mem_address, write_byte
//  output  | out_valid/ out_ready | read_byte, done_flag, pc..sp_value
//
//  A host write, a host read and a tick each step through their own states, paced by
//  the single memory port (opcode, operand bytes, data, two stores).
//  Two-entry input queue keeps taking words while a result waits, until it is full.
//  rst_n clears registers and control; memory is not cleared.
// ----------------------------------------------------------------------------
module sm83_subset_cpu_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] mem_address,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic        done_flag,
    output logic [15:0] pc_value,
    output logic [15:0] af_value,
    output logic [15:0] bc_value,
    output logic [15:0] de_value,
    output logic [15:0] hl_value,
    output logic [15:0] sp_value
);

    sm83_pkg::item_t in_item, q_item;
    logic            q_valid, q_pop;

    assign in_item = '{func: func, addr: mem_address, wbyte: write_byte};

    sm83_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sm83_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_byte (read_byte),
        .done_flag (done_flag),
        .pc_value  (pc_value),
        .af_value  (af_value),
        .bc_value  (bc_value),
        .de_value  (de_value),
        .hl_value  (hl_value),
        .sp_value  (sp_value)
    );

endmodule

// ----- src/sm83_chk.sv -----
// ----------------------------------------------------------------------------
// sm83_chk
// Port-level checks for the SM83 subset core.
// ----------------------------------------------------------------------------
module sm83_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_byte,
    input logic        done_flag,
    input logic [15:0] pc_value,
    input logic [7:0]  af_lo
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pc_value))
        else $error("result word dropped or changed while stalled");

    a_done_rb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_flag |-> read_byte == 8'h00)
        else $error("read data on a completing tick");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> af_lo[3:0] == 4'h0)
        else $error("flag low nibble not zero");

endmodule

bind sm83_subset_cpu_core sm83_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_byte (read_byte),
    .done_flag (done_flag),
    .pc_value  (pc_value),
    .af_lo     (af_value[7:0])
);
